### hdl/tbqs_pkg.sv
// Shared types and constants for the token bucket queue shaper.
// No dependencies; used by every module of the block.
package tbqs_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int SIZE_BITS_DEFAULT   = 16;

   // Configuration register indexes and reset values
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOKEN_RATE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_SIZE = 1'b1;
   localparam int TOKEN_RATE_RESET  = 2;
   localparam int BUCKET_SIZE_RESET = 5;

   // Request command encoding
   localparam logic CMD_IDLE = 1'b1;

   // Result event kinds
   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] EV_QUEUED_SENT     = 3'd0;
   localparam logic [KIND_W-1:0] EV_ARRIVAL_SENT    = 3'd1;
   localparam logic [KIND_W-1:0] EV_ARRIVAL_QUEUED  = 3'd2;
   localparam logic [KIND_W-1:0] EV_ARRIVAL_DROPPED = 3'd3;
   localparam logic [KIND_W-1:0] EV_IDLE_NONE       = 3'd4;

   typedef enum logic {
      OP_ARRIVAL,
      OP_IDLE
   } op_type;

   typedef enum logic [1:0] {
      BK_WAIT,
      BK_READ,
      BK_DECIDE
   } back_state_type;

   // Head of the command queue as seen by the back end
   typedef struct packed {
      logic   valid;
      op_type op;
   } cmd_status_type;

endpackage

### hdl/token_bucket_queue_shaper_unit.sv
// Token bucket shaper top level: configuration registers, front end, back end.
// Depends on tbqs_pkg, tbqs_front and tbqs_back.
//
// Each request transaction is one time unit. cmd 0 is a unit with a packet
// arrival of packet_size tokens, cmd 1 an idle unit. At the start of a unit
// the bucket gains token_rate tokens and is clipped to bucket_size. An
// arrival first sends queued packets from the head while the tokens cover
// them, then sends the arrival, queues it, or drops it when the wait queue
// is full. An idle unit sends at most one queued packet. Every event is one
// response transaction; rsp_last marks the final one of a unit. A head
// packet larger than the bucket blocks the wait queue for good. In the back
// end a unit goes WAIT, DECIDE, and READ then DECIDE again for each queued
// packet sent on an arrival (the head entry is re-read from the wait queue
// memory after every pop); response stalls hold it in DECIDE. A two-entry
// command queue lets new requests be taken while the back end works, and the
// response register lets the back end go on while a result waits.
// Configuration writes (index 0 token_rate, 1 bucket_size) are always
// accepted and belong only to quiet periods.
module token_bucket_queue_shaper_unit #(
   parameter int QUEUE_DEPTH = tbqs_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int SIZE_BITS   = tbqs_pkg::SIZE_BITS_DEFAULT,
   localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [SIZE_BITS-1:0]              req_packet_size,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tbqs_pkg::KIND_W-1:0]       rsp_event_kind,
   output logic [SIZE_BITS-1:0]              rsp_sent_size,
   output logic [SIZE_BITS-1:0]              rsp_tokens_left,
   output logic [COUNT_W-1:0]                rsp_queue_count,
   output logic                              rsp_last,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tbqs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [SIZE_BITS-1:0]              csr_data
);

   logic [SIZE_BITS-1:0] rate_ff;
   logic [SIZE_BITS-1:0] bucket_ff;
   logic                 csr_write;

   tbqs_pkg::cmd_status_type q_stat;
   logic [SIZE_BITS-1:0]     q_size;
   logic                     q_pop;

   // Register writes never stall
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= SIZE_BITS'(tbqs_pkg::TOKEN_RATE_RESET);
         bucket_ff <= SIZE_BITS'(tbqs_pkg::BUCKET_SIZE_RESET);
      end else if (csr_write) begin
         case (csr_index)
            tbqs_pkg::CSR_TOKEN_RATE:  rate_ff   <= csr_data;
            tbqs_pkg::CSR_BUCKET_SIZE: bucket_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Front end: takes and classifies requests
   tbqs_front #(
      .SIZE_BITS (SIZE_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_packet_size (req_packet_size),
      .q_stat          (q_stat),
      .q_size          (q_size),
      .q_pop           (q_pop)
   );

   // Back end: bucket update, wait queue, event generation
   tbqs_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .SIZE_BITS   (SIZE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .token_rate      (rate_ff),
      .bucket_size     (bucket_ff),
      .q_stat          (q_stat),
      .q_size          (q_size),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_sent_size   (rsp_sent_size),
      .rsp_tokens_left (rsp_tokens_left),
      .rsp_queue_count (rsp_queue_count),
      .rsp_last        (rsp_last)
   );

endmodule

### hdl/tbqs_front.sv
// Front end: accepts request transactions, classifies them and holds them
// in a two-entry command queue. Depends on tbqs_pkg.
module tbqs_front #(
   parameter int SIZE_BITS = tbqs_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic [SIZE_BITS-1:0]       req_packet_size,
   output tbqs_pkg::cmd_status_type   q_stat,
   output logic [SIZE_BITS-1:0]       q_size,
   input  logic                       q_pop
);

   tbqs_pkg::op_type     ent_op_ff   [2];
   logic [SIZE_BITS-1:0] ent_size_ff [2];
   logic                 wr_ff, wr_in;
   logic                 rd_ff, rd_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 push;
   tbqs_pkg::op_type     op_class;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign op_class  = (req_cmd == tbqs_pkg::CMD_IDLE) ? tbqs_pkg::OP_IDLE
                                                      : tbqs_pkg::OP_ARRIVAL;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = q_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_op_ff[wr_ff]   <= op_class;
         ent_size_ff[wr_ff] <= req_packet_size;
      end
   end

   assign q_stat.valid = (cnt_ff != 2'd0);
   assign q_stat.op    = ent_op_ff[rd_ff];
   assign q_size       = ent_size_ff[rd_ff];

endmodule

### hdl/tbqs_back.sv
// Back end: token bucket, wait queue memory and result register.
// Depends on tbqs_pkg; fed by tbqs_front.
module tbqs_back #(
   parameter int QUEUE_DEPTH = tbqs_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int SIZE_BITS   = tbqs_pkg::SIZE_BITS_DEFAULT,
   localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1),
   localparam int IDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [SIZE_BITS-1:0]           token_rate,
   input  logic [SIZE_BITS-1:0]           bucket_size,
   input  tbqs_pkg::cmd_status_type       q_stat,
   input  logic [SIZE_BITS-1:0]           q_size,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tbqs_pkg::KIND_W-1:0]    rsp_event_kind,
   output logic [SIZE_BITS-1:0]           rsp_sent_size,
   output logic [SIZE_BITS-1:0]           rsp_tokens_left,
   output logic [COUNT_W-1:0]             rsp_queue_count,
   output logic                           rsp_last
);

   tbqs_pkg::back_state_type st_ff, st_in;

   logic [SIZE_BITS-1:0] tok_ff, tok_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [COUNT_W-1:0]   fill_ff, fill_in;
   tbqs_pkg::op_type     op_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic [SIZE_BITS-1:0] rd_ff;
   logic [SIZE_BITS-1:0] mem [QUEUE_DEPTH];

   logic                        out_valid_ff, out_valid_in;
   logic [tbqs_pkg::KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [SIZE_BITS-1:0]        out_size_ff, out_size_in;
   logic [SIZE_BITS-1:0]        out_tok_ff;
   logic [COUNT_W-1:0]          out_cnt_ff;
   logic                        out_last_ff, out_last_in;

   logic                 out_free;
   logic                 fire;
   logic                 head_fits;
   logic                 arr_fits;
   logic                 has_room;
   logic                 do_pop;
   logic                 do_push;
   logic [SIZE_BITS:0]   refill_sum;
   logic [SIZE_BITS-1:0] refill_tok;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign head_fits  = (fill_ff != '0) && (tok_ff >= rd_ff);
   assign arr_fits   = (tok_ff >= size_ff);
   assign has_room   = (fill_ff < COUNT_W'(QUEUE_DEPTH));
   assign refill_sum = {1'b0, tok_ff} + {1'b0, token_rate};
   assign refill_tok = (refill_sum < {1'b0, bucket_size}) ? refill_sum[SIZE_BITS-1:0]
                                                          : bucket_size;

   // Next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         tbqs_pkg::BK_WAIT: begin
            if (q_stat.valid) st_in = tbqs_pkg::BK_DECIDE;
         end
         tbqs_pkg::BK_READ: begin
            st_in = tbqs_pkg::BK_DECIDE;
         end
         tbqs_pkg::BK_DECIDE: begin
            if (out_free) begin
               if (op_ff == tbqs_pkg::OP_ARRIVAL && head_fits) st_in = tbqs_pkg::BK_READ;
               else st_in = tbqs_pkg::BK_WAIT;
            end
         end
         default: st_in = tbqs_pkg::BK_WAIT;
      endcase
   end

   // Outputs and datapath controls
   always_comb begin
      q_pop       = 1'b0;
      fire        = 1'b0;
      do_pop      = 1'b0;
      do_push     = 1'b0;
      tok_in      = tok_ff;
      out_kind_in = tbqs_pkg::EV_IDLE_NONE;
      out_size_in = '0;
      out_last_in = 1'b1;
      case (st_ff)
         tbqs_pkg::BK_WAIT: begin
            q_pop = q_stat.valid;
            if (q_stat.valid) tok_in = refill_tok;
         end
         tbqs_pkg::BK_DECIDE: begin
            fire = out_free;
            if (head_fits) begin
               do_pop      = out_free;
               tok_in      = tok_ff - rd_ff;
               out_kind_in = tbqs_pkg::EV_QUEUED_SENT;
               out_size_in = rd_ff;
               out_last_in = (op_ff == tbqs_pkg::OP_IDLE);
            end else if (op_ff == tbqs_pkg::OP_IDLE) begin
               out_kind_in = tbqs_pkg::EV_IDLE_NONE;
            end else if (arr_fits) begin
               tok_in      = tok_ff - size_ff;
               out_kind_in = tbqs_pkg::EV_ARRIVAL_SENT;
               out_size_in = size_ff;
            end else if (has_room) begin
               do_push     = out_free;
               out_kind_in = tbqs_pkg::EV_ARRIVAL_QUEUED;
               out_size_in = size_ff;
            end else begin
               out_kind_in = tbqs_pkg::EV_ARRIVAL_DROPPED;
               out_size_in = size_ff;
            end
            if (!out_free) tok_in = tok_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (do_pop) begin
         head_in = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end
      if (do_push) begin
         tail_in = (tail_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         fill_in = fill_ff + 1'b1;
      end
      out_valid_in = out_valid_ff;
      if (rsp_ready) out_valid_in = 1'b0;
      if (fire) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= tbqs_pkg::BK_WAIT;
         tok_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         tok_ff       <= tok_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff   <= q_stat.op;
         size_ff <= q_size;
      end
      if (fire) begin
         out_kind_ff <= out_kind_in;
         out_size_ff <= out_size_in;
         out_tok_ff  <= tok_in;
         out_cnt_ff  <= fill_in;
         out_last_ff <= out_last_in;
      end
   end

   // Wait queue memory, registered read of the head entry
   always_ff @(posedge clock) begin
      if (do_push) mem[tail_ff] <= size_ff;
      rd_ff <= mem[head_ff];
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_kind  = out_kind_ff;
   assign rsp_sent_size   = out_size_ff;
   assign rsp_tokens_left = out_tok_ff;
   assign rsp_queue_count = out_cnt_ff;
   assign rsp_last        = out_last_ff;

endmodule

### hdl/tbqs_checker.sv
// Port-level checks for the token bucket queue shaper, bound to the top level.
// Depends on tbqs_pkg and token_bucket_queue_shaper_unit.
module tbqs_checker #(
   parameter int QUEUE_DEPTH = tbqs_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int SIZE_BITS   = tbqs_pkg::SIZE_BITS_DEFAULT,
   localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1)
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tbqs_pkg::KIND_W-1:0] rsp_event_kind,
   input logic [SIZE_BITS-1:0]        rsp_sent_size,
   input logic [COUNT_W-1:0]          rsp_queue_count,
   input logic                        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_queue_count <= COUNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_idle_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == tbqs_pkg::EV_IDLE_NONE
         |-> rsp_sent_size == '0 && rsp_last)
      else $error("idle event with size or not last");

   a_arrival_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == tbqs_pkg::EV_ARRIVAL_SENT ||
                    rsp_event_kind == tbqs_pkg::EV_ARRIVAL_QUEUED ||
                    rsp_event_kind == tbqs_pkg::EV_ARRIVAL_DROPPED) |-> rsp_last)
      else $error("arrival event not last of its unit");

endmodule

bind token_bucket_queue_shaper_unit tbqs_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH),
   .SIZE_BITS   (SIZE_BITS)
) u_tbqs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_event_kind  (rsp_event_kind),
   .rsp_sent_size   (rsp_sent_size),
   .rsp_queue_count (rsp_queue_count),
   .rsp_last        (rsp_last)
);
